// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on clk with rst_n low as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/smac_pkg.sv
// ----------------------------------------------------------------------------
// smac_pkg
// Types and constants for the moving-average crossover block.
// ----------------------------------------------------------------------------
package smac_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int PRICE_BITS = 32;
    localparam int SUM_W      = 38;
    localparam int SEEN_W     = 7;
    localparam int Q_FRAC     = 16;
    localparam int DIV_STEPS  = 64;

    localparam logic [63:0] START_CASH  = 64'd10000 << Q_FRAC;
    localparam logic [31:0] PERCENT_DIV = 32'd100;

    localparam logic [0:0] REG_SHORT = 1'b0;
    localparam logic [0:0] REG_LONG  = 1'b1;

    localparam logic [1:0] ACT_HOLD = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_S,
        S_RD_L,
        S_SUM,
        S_MUL_A,
        S_MUL_B,
        S_CMP,
        S_SELL_LO,
        S_SELL_HI,
        S_SELL_ADD,
        S_SELL_ACC,
        S_LAST,
        S_ROI,
        S_DIV,
        S_DIV_END,
        S_OUT
    } state_t;

endpackage

// File: src/smac_ram.sv
// ----------------------------------------------------------------------------
// smac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/sma_crossover_backtest.sv
// Sequence: an item passes the ring reads and the sums on to its result; a
// compare adds the multiplies, a sell the sell steps, and a buy whose quotient
// fits in 64 bits the 64-step shift-subtract divider, which the final ROI by 100
// shares. Items are taken one at a time, each until its result is taken.
// Reset: rst_n asynchronous active low; windows go to 5 and 10, the series
// state restarts, the price ring is left as is (read only after written).
// ----------------------------------------------------------------------------
// sma_crossover_backtest
// Moving-average crossover strategy over a price stream, with ROI on the
// last item, driven by a small sequencer around one shared divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sma_crossover_backtest (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] price
    input  logic        s_tlast,   // last_item
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] action, [33:2] roi_percent, rest zero
    output logic        m_tlast,   // is_final
    // configuration
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int PW = smac_pkg::PTR_W;
    localparam int SW = smac_pkg::SUM_W;
    localparam int NW = smac_pkg::SEEN_W;

    smac_pkg::state_t state_reg, state_next;

    // configuration
    logic [5:0]  short_win_reg, short_win_next;
    logic [6:0]  long_win_reg,  long_win_next;

    // series state
    logic [PW-1:0] ptr_reg,   ptr_next;
    logic [NW-1:0] seen_reg,  seen_next;
    logic [SW-1:0] ssum_reg,  ssum_next;
    logic [SW-1:0] lsum_reg,  lsum_next;
    logic [63:0]   cash_reg,  cash_next;
    logic [63:0]   pos_reg,   pos_next;
    logic          holding_reg, holding_next;

    // per-item working registers
    logic [31:0]   price_reg, price_next;
    logic          last_reg,  last_next;
    logic [31:0]   sdat_reg,  sdat_next;
    logic [SW+6:0] prod_a_reg, prod_a_next;
    logic [SW+6:0] prod_b_reg, prod_b_next;
    logic [63:0]   pp_lo_reg, pp_lo_next;
    logic [63:0]   pp_hi_reg, pp_hi_next;
    logic [63:0]   gain_reg,  gain_next;
    logic          ret_roi_reg, ret_roi_next;   // sell is the closing one

    // shared divider
    logic [32:0]   rem_reg,   rem_next;
    logic [63:0]   low_reg,   low_next;
    logic [63:0]   quo_reg,   quo_next;
    logic [31:0]   dvs_reg,   dvs_next;
    logic [5:0]    cnt_reg,   cnt_next;
    logic          div_buy_reg, div_buy_next;
    logic          neg_reg,   neg_next;

    // result
    logic [1:0]    action_reg, action_next;
    logic          final_reg,  final_next;
    logic [31:0]   roi_reg,    roi_next;

    // ring
    logic          ram_we;
    logic [PW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic          win_ok;
    logic [NW-1:0] seen_inc;
    logic          trade_en;
    logic [33:0]   trial;
    logic [32:0]   rem_sh;
    logic [64:0]   cash_sum;
    logic          div_busy;

    smac_ram #(
        .WIDTH (smac_pkg::PRICE_BITS),
        .DEPTH (smac_pkg::MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (price_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign win_ok = (short_win_reg != 6'd0) && ({1'b0, short_win_reg} < long_win_reg)
                 && (long_win_reg <= 7'(smac_pkg::MAX_WINDOW));

    // saturating items-seen count after this item
    assign seen_inc = (seen_reg < NW'(smac_pkg::MAX_WINDOW + 1)) ? seen_reg + 1'b1 : seen_reg;
    assign trade_en = win_ok && (seen_inc >= long_win_reg)
                   && !(last_reg && (seen_inc == long_win_reg));

    // one restoring division step
    assign rem_sh   = {rem_reg[31:0], low_reg[63]};
    assign trial    = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign cash_sum = {1'b0, cash_reg} + {1'b0, gain_reg};

    assign s_tready = (state_reg == smac_pkg::S_IDLE);
    assign m_tvalid = (state_reg == smac_pkg::S_OUT);
    assign m_tdata  = {6'd0, roi_reg, action_reg};
    assign m_tlast  = final_reg;
    assign ram_we   = (state_reg == smac_pkg::S_SUM);
    assign ram_raddr = (state_reg == smac_pkg::S_RD_S) ? ptr_reg - short_win_reg
                                                      : ptr_reg - long_win_reg[PW-1:0];
    assign div_busy = (state_reg == smac_pkg::S_DIV) && (cnt_reg != 6'd0);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smac_pkg::S_IDLE:     if (s_tvalid) state_next = smac_pkg::S_RD_S;
            smac_pkg::S_RD_S:     state_next = smac_pkg::S_RD_L;
            smac_pkg::S_RD_L:     state_next = smac_pkg::S_SUM;
            smac_pkg::S_SUM:      state_next = trade_en ? smac_pkg::S_MUL_A : smac_pkg::S_LAST;
            smac_pkg::S_MUL_A:    state_next = smac_pkg::S_MUL_B;
            smac_pkg::S_MUL_B:    state_next = smac_pkg::S_CMP;
            smac_pkg::S_CMP:
            begin
                priority if (prod_a_reg > prod_b_reg && !holding_reg && price_reg != 32'd0)
                    state_next = (price_reg <= cash_reg[63:32]) ? smac_pkg::S_LAST
                                                                : smac_pkg::S_DIV;
                else if (prod_a_reg < prod_b_reg && holding_reg)
                    state_next = smac_pkg::S_SELL_LO;
                else
                    state_next = smac_pkg::S_LAST;
            end
            smac_pkg::S_SELL_LO:  state_next = smac_pkg::S_SELL_HI;
            smac_pkg::S_SELL_HI:  state_next = smac_pkg::S_SELL_ADD;
            smac_pkg::S_SELL_ADD: state_next = smac_pkg::S_SELL_ACC;
            smac_pkg::S_SELL_ACC: state_next = ret_roi_reg ? smac_pkg::S_ROI : smac_pkg::S_LAST;
            smac_pkg::S_LAST:
            begin
                priority if (last_reg && win_ok && seen_reg > long_win_reg)
                    state_next = holding_reg ? smac_pkg::S_SELL_LO : smac_pkg::S_ROI;
                else
                    state_next = smac_pkg::S_OUT;
            end
            smac_pkg::S_ROI:      state_next = smac_pkg::S_DIV;
            smac_pkg::S_DIV:      if (cnt_reg == 6'd0) state_next = smac_pkg::S_DIV_END;
            smac_pkg::S_DIV_END:  state_next = div_buy_reg ? smac_pkg::S_LAST : smac_pkg::S_OUT;
            smac_pkg::S_OUT:      if (m_tready) state_next = smac_pkg::S_IDLE;
            default:              state_next = smac_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        short_win_next = short_win_reg;
        long_win_next  = long_win_reg;
        ptr_next       = ptr_reg;
        seen_next      = seen_reg;
        ssum_next      = ssum_reg;
        lsum_next      = lsum_reg;
        cash_next      = cash_reg;
        pos_next       = pos_reg;
        holding_next   = holding_reg;
        price_next     = price_reg;
        last_next      = last_reg;
        sdat_next      = sdat_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        pp_lo_next     = pp_lo_reg;
        pp_hi_next     = pp_hi_reg;
        gain_next      = gain_reg;
        ret_roi_next   = ret_roi_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        div_buy_next   = div_buy_reg;
        neg_next       = neg_reg;
        action_next    = action_reg;
        final_next     = final_reg;
        roi_next       = roi_reg;

        unique case (state_reg)
            smac_pkg::S_IDLE:
            begin
                price_next  = s_tdata;
                last_next   = s_tlast;
                action_next = smac_pkg::ACT_HOLD;
                final_next  = 1'b0;
                roi_next    = 32'd0;
                ret_roi_next = 1'b0;
            end
            smac_pkg::S_RD_S: ;
            smac_pkg::S_RD_L:
            begin
                sdat_next = ram_rdata;
            end
            smac_pkg::S_SUM:
            begin
                if (win_ok)
                begin
                    ssum_next = ssum_reg + SW'(price_reg)
                              - ((seen_reg >= {1'b0, short_win_reg}) ? SW'(sdat_reg) : '0);
                    lsum_next = lsum_reg + SW'(price_reg)
                              - ((seen_reg >= long_win_reg) ? SW'(ram_rdata) : '0);
                end
                ptr_next  = ptr_reg + 1'b1;
                seen_next = seen_inc;
            end
            smac_pkg::S_MUL_A:
            begin
                prod_a_next = (SW+7)'(ssum_reg) * (SW+7)'(long_win_reg);
            end
            smac_pkg::S_MUL_B:
            begin
                prod_b_next = (SW+7)'(lsum_reg) * (SW+7)'(short_win_reg);
            end
            smac_pkg::S_CMP:
            begin
                priority if (prod_a_reg > prod_b_reg && !holding_reg && price_reg != 32'd0)
                begin
                    action_next = smac_pkg::ACT_BUY;
                    if (price_reg <= cash_reg[63:32])
                    begin
                        // quotient overflows 64 bits
                        pos_next     = '1;
                        cash_next    = 64'd0;
                        holding_next = 1'b1;
                    end
                    else
                    begin
                        rem_next     = {1'b0, cash_reg[63:32]};
                        low_next     = {cash_reg[31:0], 32'd0};
                        quo_next     = 64'd0;
                        dvs_next     = price_reg;
                        cnt_next     = 6'(smac_pkg::DIV_STEPS - 1);
                        div_buy_next = 1'b1;
                    end
                end
                else if (prod_a_reg < prod_b_reg && holding_reg)
                begin
                    action_next = smac_pkg::ACT_SELL;
                end
                else
                begin
                end
            end
            smac_pkg::S_SELL_LO:
            begin
                pp_lo_next = 64'(pos_reg[31:0]) * 64'(price_reg);
            end
            smac_pkg::S_SELL_HI:
            begin
                pp_hi_next = 64'(pos_reg[63:32]) * 64'(price_reg);
            end
            smac_pkg::S_SELL_ADD:
            begin
                gain_next = pp_hi_reg + {32'd0, pp_lo_reg[63:32]};
            end
            smac_pkg::S_SELL_ACC:
            begin
                cash_next    = cash_sum[64] ? '1 : cash_sum[63:0];
                pos_next     = 64'd0;
                holding_next = 1'b0;
            end
            smac_pkg::S_LAST:
            begin
                if (last_reg)
                begin
                    final_next = 1'b1;
                    if (win_ok && seen_reg > long_win_reg && holding_reg)
                    begin
                        ret_roi_next = 1'b1;
                    end
                end
            end
            smac_pkg::S_ROI:
            begin
                if (cash_reg >= smac_pkg::START_CASH)
                begin
                    low_next = cash_reg - smac_pkg::START_CASH;
                    neg_next = 1'b0;
                end
                else
                begin
                    low_next = smac_pkg::START_CASH - cash_reg;
                    neg_next = 1'b1;
                end
                rem_next     = 33'd0;
                quo_next     = 64'd0;
                dvs_next     = smac_pkg::PERCENT_DIV;
                cnt_next     = 6'(smac_pkg::DIV_STEPS - 1);
                div_buy_next = 1'b0;
            end
            smac_pkg::S_DIV:
            begin
                rem_next = trial[33] ? rem_sh : trial[32:0];
                low_next = {low_reg[62:0], 1'b0};
                quo_next = {quo_reg[62:0], ~trial[33]};
                cnt_next = cnt_reg - 1'b1;
            end
            smac_pkg::S_DIV_END:
            begin
                if (div_buy_reg)
                begin
                    pos_next     = quo_reg;
                    cash_next    = 64'd0;
                    holding_next = 1'b1;
                    div_buy_next = 1'b0;
                end
                else if (neg_reg)
                begin
                    roi_next = 32'd0 - quo_reg[31:0];
                end
                else
                begin
                    roi_next = (quo_reg[63:31] != '0) ? 32'h7FFF_FFFF : quo_reg[31:0];
                end
            end
            smac_pkg::S_OUT:
            begin
                if (m_tready && last_reg)
                begin
                    // series restarts after the final result
                    ptr_next     = '0;
                    seen_next    = '0;
                    ssum_next    = '0;
                    lsum_next    = '0;
                    cash_next    = smac_pkg::START_CASH;
                    pos_next     = 64'd0;
                    holding_next = 1'b0;
                end
            end
            default: ;
        endcase

        // register write also restarts the series
        if (cfg_we)
        begin
            unique case (cfg_index)
                smac_pkg::REG_SHORT: short_win_next = cfg_data[5:0];
                smac_pkg::REG_LONG:  long_win_next  = cfg_data;
                default: ;
            endcase
            ptr_next     = '0;
            seen_next    = '0;
            ssum_next    = '0;
            lsum_next    = '0;
            cash_next    = smac_pkg::START_CASH;
            pos_next     = 64'd0;
            holding_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smac_pkg::S_IDLE;
            short_win_reg <= 6'd5;
            long_win_reg  <= 7'd10;
            ptr_reg       <= '0;
            seen_reg      <= '0;
            ssum_reg      <= '0;
            lsum_reg      <= '0;
            cash_reg      <= smac_pkg::START_CASH;
            pos_reg       <= '0;
            holding_reg   <= 1'b0;
            div_buy_reg   <= 1'b0;
            ret_roi_reg   <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            short_win_reg <= short_win_next;
            long_win_reg  <= long_win_next;
            ptr_reg       <= ptr_next;
            seen_reg      <= seen_next;
            ssum_reg      <= ssum_next;
            lsum_reg      <= lsum_next;
            cash_reg      <= cash_next;
            pos_reg       <= pos_next;
            holding_reg   <= holding_next;
            div_buy_reg   <= div_buy_next;
            ret_roi_reg   <= ret_roi_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        price_reg  <= price_next;
        last_reg   <= last_next;
        sdat_reg   <= sdat_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        pp_lo_reg  <= pp_lo_next;
        pp_hi_reg  <= pp_hi_next;
        gain_reg   <= gain_next;
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        action_reg <= action_next;
        final_reg  <= final_next;
        roi_reg    <= roi_next;
    end

    // ---------------------------------------------------------------- checks
    `ASSERT_SAME(a_hold_no_cash, holding_reg, cash_reg == 64'd0)
    `ASSERT_SAME(a_flat_no_pos, !holding_reg, pos_reg == 64'd0)
    `ASSERT_SAME(a_one_item, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_div_runs, div_busy && !cfg_we, state_reg == smac_pkg::S_DIV)

endmodule

// File: verif/sma_crossover_backtest_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sma_crossover_backtest_test
// Self-checking bench: prices go in as stream transfers, a local trading model
// predicts action, final flag and ROI, and each result transfer is checked.
// ----------------------------------------------------------------------------
module sma_crossover_backtest_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_ITEMS   = 1750;

    typedef struct {
        logic [1:0]  action;
        logic        is_final;
        logic [31:0] roi;
    } trade_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    // trading model state
    logic [5:0]  mdl_short_win;
    logic [6:0]  mdl_long_win;
    logic [31:0] mdl_ring [smac_pkg::MAX_WINDOW];
    int          mdl_ptr;
    int          mdl_seen;
    logic [63:0] mdl_short_sum;
    logic [63:0] mdl_long_sum;
    logic [63:0] mdl_cash;
    logic [63:0] mdl_position;
    logic        mdl_holding;

    trade_result_t expected_trades[$];
    int  mismatches = 0;
    int  items_sent;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;   // stretch with no gaps and no stalls
    int  ready_hold = 0;

    sma_crossover_backtest dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [31:0] price
        .s_tlast  (s_tlast),     // last_item
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [1:0] action, [33:2] roi_percent
        .m_tlast  (m_tlast),     // is_final
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Trading model
    // ------------------------------------------------------------------
    function automatic void restart_series();
        mdl_ptr       = 0;
        mdl_seen      = 0;
        mdl_short_sum = '0;
        mdl_long_sum  = '0;
        mdl_cash      = smac_pkg::START_CASH;
        mdl_position  = '0;
        mdl_holding   = 1'b0;
    endfunction

    function automatic void close_position(logic [31:0] p);
        logic [127:0] prod;
        logic [127:0] gain;
        logic [64:0]  total;
        prod = 128'(mdl_position) * 128'(p);
        gain = prod >> 32;
        if (gain[127:64] != '0)
            gain = 128'({64{1'b1}});
        total = {1'b0, mdl_cash} + {1'b0, gain[63:0]};
        mdl_cash     = total[64] ? {64{1'b1}} : total[63:0];
        mdl_position = '0;
        mdl_holding  = 1'b0;
    endfunction

    function automatic trade_result_t trade_on_price(logic [31:0] p, logic last);
        trade_result_t r;
        bit           win_ok;
        int           prev;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] qty;
        logic [63:0]  d;
        r      = '{action: smac_pkg::ACT_HOLD, is_final: 1'b0, roi: '0};
        win_ok = mdl_short_win >= 1 && 7'(mdl_short_win) < mdl_long_win
                 && mdl_long_win <= smac_pkg::MAX_WINDOW;
        prev   = mdl_seen;
        if (win_ok)
        begin
            mdl_short_sum += 64'(p);
            if (prev >= mdl_short_win)
                mdl_short_sum -= 64'(mdl_ring[(mdl_ptr + smac_pkg::MAX_WINDOW - mdl_short_win)
                                              % smac_pkg::MAX_WINDOW]);
            mdl_long_sum += 64'(p);
            if (prev >= mdl_long_win)
                mdl_long_sum -= 64'(mdl_ring[(mdl_ptr + smac_pkg::MAX_WINDOW - mdl_long_win)
                                             % smac_pkg::MAX_WINDOW]);
        end
        mdl_ring[mdl_ptr] = p;
        mdl_ptr = (mdl_ptr + 1) % smac_pkg::MAX_WINDOW;
        if (mdl_seen < smac_pkg::MAX_WINDOW + 1)
            mdl_seen++;

        // averages compared by cross-multiplying the sums
        if (win_ok && mdl_seen >= mdl_long_win && !(last && mdl_seen == mdl_long_win))
        begin
            lhs = 128'(mdl_short_sum) * 128'(mdl_long_win);
            rhs = 128'(mdl_long_sum) * 128'(mdl_short_win);
            if (lhs > rhs && !mdl_holding && p != 0)
            begin
                qty = {mdl_cash, 32'b0} / 128'(p);
                mdl_position = (qty[127:64] != '0) ? {64{1'b1}} : qty[63:0];
                mdl_cash     = '0;
                mdl_holding  = 1'b1;
                r.action     = smac_pkg::ACT_BUY;
            end
            else if (lhs < rhs && mdl_holding)
            begin
                close_position(p);
                r.action = smac_pkg::ACT_SELL;
            end
        end

        if (last)
        begin
            r.is_final = 1'b1;
            if (win_ok && mdl_seen > mdl_long_win)
            begin
                if (mdl_holding)
                    close_position(p);
                if (mdl_cash >= smac_pkg::START_CASH)
                begin
                    d = (mdl_cash - smac_pkg::START_CASH) / 64'(smac_pkg::PERCENT_DIV);
                    r.roi = (d > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : d[31:0];
                end
                else
                begin
                    d = (smac_pkg::START_CASH - mdl_cash) / 64'(smac_pkg::PERCENT_DIV);
                    r.roi = 32'(-d);
                end
            end
            restart_series();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // one price transfer; returns just after the accepting edge
    task automatic send_price(logic [31:0] p, logic last);
        int            gap;
        trade_result_t exp_r;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        exp_r = trade_on_price(p, last);
        expected_trades.insert(expected_trades.size(), exp_r);
        items_sent++;
    endtask

    // hold off the sender until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_trades.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [6:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == smac_pkg::REG_SHORT)
            mdl_short_win = val[5:0];
        else
            mdl_long_win = val;
        restart_series();
    endtask

    task automatic set_windows(logic [6:0] sw, logic [6:0] lw);
        write_reg(smac_pkg::REG_SHORT, sw);
        write_reg(smac_pkg::REG_LONG, lw);
    endtask

    // random-walk series with a drift that flips, so the averages cross
    task automatic send_series(int len, logic [31:0] start, int step, bit noisy);
        logic [63:0] p;
        int          drift;
        int          delta;
        p     = start;
        drift = step / 2;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                drift = -drift;
            delta = $urandom_range(0, 2 * step) - step + drift;
            if (delta < 0 && p <= 64'(-delta))
                p = 64'($urandom_range(1, 1000));
            else
                p = p + 64'(signed'(delta));
            if (p > 64'hFFFF_FFFF)
                p = 64'hFFFF_FFFF;
            if (noisy && $urandom_range(0, 3) == 0)
                p = 64'($urandom_range(1, 32'hFFFF_FFFF));
            send_price(p[31:0], i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        trade_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_trades.size() == 0)
            begin
                $error("result with nothing expected: tdata %h tlast %b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                exp_r = expected_trades.pop_front();
                if (m_tdata[1:0] !== exp_r.action)
                begin
                    $error("action: expected %0d, got %0d", exp_r.action, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tlast !== exp_r.is_final)
                begin
                    $error("is_final: expected %b, got %b", exp_r.is_final, m_tlast);
                    mismatches++;
                end
                if (m_tdata[33:2] !== exp_r.roi)
                begin
                    $error("roi_percent: expected %h, got %h", exp_r.roi, m_tdata[33:2]);
                    mismatches++;
                end
            end
        end
    end

    // receiver stalls: mostly short, a few long
    always @(posedge clk)
    begin
        int r;
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (quiet || r < 65)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                ready_hold = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 50);
            end
        end
    end

    // quiet stretches come and go
    always @(posedge clk)
        if ($urandom_range(0, 399) == 0)
            quiet <= ~quiet;

    // watchdog on cycles with no transfer on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_windows();
        // rise then fall with default windows 5 and 10: buy, then sell
        for (int i = 0; i < 14; i++)
            send_price(32'h0010_0000 + 32'(i) * 32'h0002_0000, 1'b0);
        for (int i = 0; i < 6; i++)
            send_price(32'h0030_0000 - 32'(i) * 32'h0008_0000, i == 5);
        // too few items: ROI stays zero
        send_price(32'h0000_0001, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'h0000_0000, 1'b1);
    endtask

    task automatic test_price_extremes();
        // tiny prices then a huge one: buy at a tiny price, ROI saturates
        set_windows(7'd1, 7'd2);
        send_price(32'h0000_0002, 1'b0);
        send_price(32'h0000_0001, 1'b0);
        send_price(32'h0000_0000, 1'b0);   // no buy at price zero
        send_price(32'h0000_0003, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b1);
        // a random series; a position still open on the last item is closed there
        send_series(12, 32'h8000_0000, 32'h0100_0000, 1'b0);
    endtask

    task automatic test_window_extremes();
        set_windows(7'd63, 7'd64);
        send_series(140, 32'h0064_0000, 32'h0004_0000, 1'b0);
        set_windows(7'd1, 7'd64);
        send_series(100, 32'h0064_0000, 32'h0004_0000, 1'b0);
        // windows that never trade
        set_windows(7'd0, 7'd10);
        send_series(20, 32'h0064_0000, 32'h0004_0000, 1'b0);
        set_windows(7'd12, 7'd12);
        send_series(20, 32'h0064_0000, 32'h0004_0000, 1'b0);
        set_windows(7'd40, 7'd127);
        send_series(70, 32'h0064_0000, 32'h0004_0000, 1'b0);
        // upper bit of the short register is masked off
        set_windows(7'h43, 7'd9);
        send_series(30, 32'h0064_0000, 32'h0004_0000, 1'b1);
    endtask

    task automatic test_random_series();
        int          lw;
        int          len;
        int          series_cnt;
        logic [31:0] start;
        series_cnt = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            if (series_cnt % 6 == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    set_windows(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                else
                begin
                    lw = $urandom_range(2, 24);
                    if ($urandom_range(0, 7) == 0)
                        lw = $urandom_range(25, 64);
                    set_windows(7'($urandom_range(1, lw - 1)), 7'(lw));
                end
            end
            else if (series_cnt == 9)
                drain_results();
            len = (mdl_long_win > 64) ? 20 : mdl_long_win + $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, (mdl_long_win > 64) ? 20 : mdl_long_win);
            start = $urandom_range(32'h0000_1000, 32'h4000_0000);
            if ($urandom_range(0, 4) == 0)
                start = $urandom_range(1, 32'hFFFF_FFFF);
            send_series(len, start, int'(start >> $urandom_range(3, 8)) + 1,
                        $urandom_range(0, 5) == 0);
            series_cnt++;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        items_sent  = 0;
        mdl_short_win = 6'd5;
        mdl_long_win  = 7'd10;
        restart_series();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_windows();
        test_price_extremes();
        test_window_extremes();
        test_random_series();

        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_trades.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
